// ----- rtl/core/page_slot_lookup_table_unit_macros.svh -----
// Assertion macros shared by the page slot lookup table RTL.
`ifndef PAGE_SLOT_LOOKUP_TABLE_UNIT_MACROS_SVH
`define PAGE_SLOT_LOOKUP_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, disabled while reset is held.
`define PSLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define PSLT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSLT_ASSERT(label, clk, rst_n, prop, msg)
`define PSLT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/core/pslt_pkg.sv -----
// Types and constants of the page slot lookup table.
package pslt_pkg;

    localparam int PSLT_CAPACITY = 64;
    localparam int ACTION_W      = 2;
    localparam int FILE_W        = 16;
    localparam int PAGE_W        = 31;
    localparam int SLOT_W        = 6;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FIND   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EXISTS    = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// ----- rtl/core/pslt_if.sv -----
// Request and response channel interfaces of the page slot lookup table.
interface psl_req_if
    import pslt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [FILE_W-1:0]   file_id;
    logic [PAGE_W-1:0]   page_number;
    logic [SLOT_W-1:0]   slot_in;

    modport source (output valid, action, file_id, page_number, slot_in, input ready);
    modport sink   (input valid, action, file_id, page_number, slot_in, output ready);
endinterface

interface psl_rsp_if
    import pslt_pkg::*;
;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [SLOT_W-1:0] slot_out;

    modport source (output valid, status, slot_out, input ready);
    modport sink   (input valid, status, slot_out, output ready);
endinterface

// ----- rtl/core/page_slot_lookup_table_unit.sv -----
// Fully associative (file id, page number) to buffer slot table, top level.
// The input stage registers a request beat, then the result stage its response.
// Throughput: one request per cycle unless o_rsp stalls, set by the parallel
// combinational key compare and lowest-free-entry pick over the register table.
// Reset: synchronous, active low; clears all entry valid marks and both stages.
// Entry contents are not reset; no clearing pass is needed.
`include "page_slot_lookup_table_unit_macros.svh"

module page_slot_lookup_table_unit
    import pslt_pkg::*;
#(
    parameter int CAPACITY = PSLT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psl_req_if.sink     i_req,
    psl_rsp_if.source   o_rsp
);

    // Input stage.
    logic                r_in_valid;
    logic [ACTION_W-1:0] r_in_action;
    logic [FILE_W-1:0]   r_in_file;
    logic [PAGE_W-1:0]   r_in_page;
    logic [SLOT_W-1:0]   r_in_slot;

    // Entry table.
    logic [CAPACITY-1:0] r_valid;
    logic [FILE_W-1:0]   r_file [CAPACITY];
    logic [PAGE_W-1:0]   r_page [CAPACITY];
    logic [SLOT_W-1:0]   r_slot [CAPACITY];

    // Result stage.
    logic                r_out_valid;
    t_status             r_out_status;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                w_advance;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_free_lo;
    logic                w_any_hit;
    logic                w_full;
    logic [SLOT_W-1:0]   w_hit_slot;
    t_status             n_status;
    logic [SLOT_W-1:0]   n_slot_out;
    logic [CAPACITY-1:0] n_set;
    logic [CAPACITY-1:0] n_clr;

    assign w_advance   = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_advance;

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.slot_out = r_out_slot;

    // Key compare against every entry at once; at most one entry can match.
    always_comb begin
        w_hit_slot = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit[i] = r_valid[i] && (r_file[i] == r_in_file) && (r_page[i] == r_in_page);
            w_hit_slot = w_hit_slot | (w_hit[i] ? r_slot[i] : '0);
        end
    end

    assign w_any_hit = |w_hit;
    assign w_full    = &r_valid;
    // Lowest clear bit of the valid vector, one-hot.
    assign w_free_lo = ~r_valid & (r_valid + CAPACITY'(1));

    always_comb begin
        n_status   = ST_NOT_FOUND;
        n_slot_out = '0;
        n_set      = '0;
        n_clr      = '0;
        case (r_in_action)
            ACT_FIND: begin
                if (w_any_hit) begin
                    n_status   = ST_OK;
                    n_slot_out = w_hit_slot;
                end
            end
            ACT_INSERT: begin
                if (w_any_hit) begin
                    n_status = ST_EXISTS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    n_set    = w_free_lo;
                end
            end
            ACT_DELETE: begin
                if (w_any_hit) begin
                    n_status = ST_OK;
                    n_clr    = w_hit;
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_valid     <= (r_valid | n_set) & ~n_clr;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_action <= i_req.action;
            r_in_file   <= i_req.file_id;
            r_in_page   <= i_req.page_number;
            r_in_slot   <= i_req.slot_in;
        end
        if (w_advance) begin
            r_out_status <= n_status;
            r_out_slot   <= n_slot_out;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_advance && n_set[i]) begin
                r_file[i] <= r_in_file;
                r_page[i] <= r_in_page;
                r_slot[i] <= r_in_slot;
            end
        end
    end

    `PSLT_ASSERT(a_unique_key, i_clk, i_rst_n, r_in_valid |-> $onehot0(w_hit), "key held by more than one entry")
    `PSLT_ASSERT(a_insert_grows, i_clk, i_rst_n, (w_advance && r_in_action == ACT_INSERT && n_status == ST_OK) |=> ($countones(r_valid) == $past($countones(r_valid)) + 1), "insert did not add exactly one entry")
    `PSLT_ASSERT(a_full_means_full, i_clk, i_rst_n, (w_advance && n_status == ST_FULL) |-> w_full, "table full reported with a free entry")
    `PSLT_ASSERT(a_slot_zero, i_clk, i_rst_n, (r_out_valid && r_out_status != ST_OK) |-> (r_out_slot == '0), "nonzero slot on a failed response")
    `PSLT_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_valid == '0 && !r_in_valid && !r_out_valid), "reset did not clear control state")

endmodule
